FILE: hw/rtl/cfrc_pkg.sv
// constants and crc helper for the crc frame receiver capture block
// no dependencies
package cfrc_pkg;

  localparam int unsigned FrameBytes = 8192;
  localparam int unsigned MaxSamples = 2048;
  localparam int unsigned BufAw      = $clog2(FrameBytes);
  localparam int unsigned CapAw      = $clog2(MaxSamples);

  localparam logic [7:0]  SyncFirst  = 8'h55;
  localparam logic [7:0]  SyncSecond = 8'hAA;
  localparam logic [7:0]  Version    = 8'h01;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'hA001;
  localparam logic [7:0]  CmdSamples = 8'h40;

  // one byte of crc-16 modbus, reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] dat);
    logic [15:0] c;
    c = crc ^ {8'h00, dat};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/crc_frame_receiver_capture.sv
// crc frame receiver capture: top level, frame buffer and capture store
// depends on cfrc_pkg
//
// Link bytes go into an 8192-byte circular frame buffer; after each byte a
// sequencer walks the buffer through its one read port, one byte per cycle:
// 8 header bytes per sync candidate, then version through crc (len + 8
// bytes), then 2*ns bytes to copy samples into the 2048-entry capture
// store. No reset sweep is needed.
module crc_frame_receiver_capture
  import cfrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  link_byte_i,
  input  logic [10:0] sample_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [9:0]  frames_done_o,
  output logic [7:0]  last_command_o,
  output logic [15:0] last_sequence_o,
  output logic [12:0] last_length_o,
  output logic        capture_updated_o,
  output logic [11:0] sample_total_o,
  output logic [15:0] sample_value_o
);

  localparam logic [2:0] StIdle = 3'd0, StRead = 3'd1, StScan = 3'd2,
                         StFetch = 3'd3, StDec = 3'd4, StFin = 3'd5;
  localparam logic [1:0] PhHdr = 2'd0, PhCrc = 2'd1, PhCopy = 2'd2;

  logic [7:0]  buf_mem [FrameBytes];
  logic [15:0] cap_mem [MaxSamples];

  logic [2:0]        state_q;
  logic [1:0]        phase_q;
  logic [BufAw-1:0]  head_q;
  logic [BufAw:0]    fill_q;
  logic [11:0]       count_q;
  logic              iss_q, rd_vld_q, rd_last_q;
  logic [BufAw-1:0]  iss_off_q, end_off_q, rd_off_q;
  logic [7:0]        rdata_q;
  logic [7:0]        hdr_q [8];
  logic [15:0]       crc_q, rx_q, ns_q, cap_rd_q;
  logic [7:0]        lo_q;
  logic [9:0]        done_q;
  logic [7:0]        l_cmd_q;
  logic [15:0]       l_seq_q;
  logic [12:0]       l_len_q;
  logic              upd_q, rd_hit_q;

  logic              out_vld_q, kind_q;
  logic [9:0]        o_done_q;
  logic [7:0]        o_cmd_q;
  logic [15:0]       o_seq_q, o_val_q;
  logic [12:0]       o_len_q;
  logic              o_upd_q;
  logic [11:0]       o_tot_q;

  logic [15:0] len;
  logic [16:0] flen;
  logic        slot_free;
  logic        buf_we;
  logic [BufAw-1:0] buf_waddr, buf_raddr;
  logic [CapAw-1:0] cap_idx;

  assign len       = {hdr_q[7], hdr_q[6]};
  assign flen      = {1'b0, len} + 17'd10;
  assign slot_free = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign buf_we    = in_valid_i && in_ready_o && !operation_i && (fill_q < (BufAw+1)'(FrameBytes));
  assign buf_waddr = head_q + fill_q[BufAw-1:0];
  assign buf_raddr = head_q + iss_off_q;
  assign cap_idx   = CapAw'((rd_off_q - BufAw'(18)) >> 1);

  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[buf_waddr] <= link_byte_i;
    rdata_q <= buf_mem[buf_raddr];
  end

  // read data held until the answer leaves
  always_ff @(posedge clk_i) begin
    if (state_q == StFetch && rd_vld_q && phase_q == PhCopy && !rd_off_q[0])
      cap_mem[cap_idx] <= {rdata_q, lo_q};
    if (in_valid_i && in_ready_o && operation_i) cap_rd_q <= cap_mem[sample_index_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      phase_q   <= PhHdr;
      head_q    <= '0;
      fill_q    <= '0;
      count_q   <= '0;
      iss_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      out_vld_q <= 1'b0;
      done_q    <= '0;
      upd_q     <= 1'b0;
    end else begin
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            if (operation_i) begin
              rd_hit_q <= {1'b0, sample_index_i} < count_q;
              state_q  <= StRead;
            end else begin
              if (buf_we) fill_q <= fill_q + 1'b1;
              done_q  <= '0;
              upd_q   <= 1'b0;
              state_q <= StScan;
            end
          end
        end
        StRead: begin
          if (slot_free) begin
            out_vld_q <= 1'b1;
            kind_q    <= 1'b1;
            o_done_q  <= '0;
            o_cmd_q   <= '0;
            o_seq_q   <= '0;
            o_len_q   <= '0;
            o_upd_q   <= 1'b0;
            o_tot_q   <= count_q;
            o_val_q   <= rd_hit_q ? cap_rd_q : 16'h0000;
            state_q   <= StIdle;
          end
        end
        StScan: begin
          if (fill_q < (BufAw+1)'(8)) begin
            state_q <= StFin;
          end else begin
            phase_q   <= PhHdr;
            iss_off_q <= '0;
            end_off_q <= BufAw'(7);
            iss_q     <= 1'b1;
            state_q   <= StFetch;
          end
        end
        StFetch: begin
          // issue stops on the last offset, so valid drops after its data
          rd_vld_q <= iss_q;
          if (iss_q) begin
            rd_off_q  <= iss_off_q;
            rd_last_q <= (iss_off_q == end_off_q);
            iss_off_q <= iss_off_q + 1'b1;
            if (iss_off_q == end_off_q) iss_q <= 1'b0;
          end
          if (rd_vld_q) begin
            case (phase_q)
              PhHdr: hdr_q[rd_off_q[2:0]] <= rdata_q;
              PhCrc: begin
                if ({3'b000, rd_off_q} <= len + 16'd7) crc_q <= crc_byte(crc_q, rdata_q);
                if (rd_off_q == BufAw'(13)) ns_q[7:0] <= rdata_q;
                if (rd_off_q == BufAw'(14)) ns_q[15:8] <= rdata_q;
                if ({3'b000, rd_off_q} == len + 16'd8) rx_q[7:0] <= rdata_q;
                if ({3'b000, rd_off_q} == len + 16'd9) rx_q[15:8] <= rdata_q;
              end
              default: if (rd_off_q[0]) lo_q <= rdata_q;
            endcase
            if (rd_last_q) begin
              state_q  <= StDec;
            end
          end
        end
        StDec: begin
          state_q <= StScan;
          case (phase_q)
            PhHdr: begin
              if (!(hdr_q[0] == SyncFirst && hdr_q[1] == SyncSecond)) begin
                head_q <= head_q + 1'b1;
                fill_q <= fill_q - 1'b1;
              end else if (hdr_q[2] != Version || flen > 17'(FrameBytes)) begin
                head_q <= head_q + BufAw'(2);
                fill_q <= fill_q - (BufAw+1)'(2);
              end else if ({3'b000, fill_q} < flen) begin
                state_q <= StFin;
              end else begin
                phase_q   <= PhCrc;
                crc_q     <= CrcInit;
                iss_off_q <= BufAw'(2);
                end_off_q <= BufAw'(len + 16'd9);
                iss_q     <= 1'b1;
                state_q   <= StFetch;
              end
            end
            PhCrc: begin
              if (crc_q != rx_q) begin
                head_q <= head_q + BufAw'(2);
                fill_q <= fill_q - (BufAw+1)'(2);
              end else begin
                done_q  <= done_q + 1'b1;
                l_cmd_q <= hdr_q[5];
                l_seq_q <= {hdr_q[4], hdr_q[3]};
                l_len_q <= len[12:0];
                if (hdr_q[5] == CmdSamples && len >= 16'd9 && ns_q != 16'd0 &&
                    ns_q <= 16'(MaxSamples) &&
                    ({1'b0, ns_q, 1'b0} + 18'd17) <= ({2'b00, len} + 18'd8)) begin
                  phase_q   <= PhCopy;
                  iss_off_q <= BufAw'(17);
                  end_off_q <= BufAw'({ns_q, 1'b0} + 17'd16);
                  iss_q     <= 1'b1;
                  state_q   <= StFetch;
                end else begin
                  head_q <= head_q + flen[BufAw-1:0];
                  fill_q <= fill_q - flen[BufAw:0];
                end
              end
            end
            default: begin
              count_q <= ns_q[11:0];
              upd_q   <= 1'b1;
              head_q  <= head_q + flen[BufAw-1:0];
              fill_q  <= fill_q - flen[BufAw:0];
            end
          endcase
        end
        StFin: begin
          if (done_q == '0) begin
            state_q <= StIdle;
          end else if (slot_free) begin
            out_vld_q <= 1'b1;
            kind_q    <= 1'b0;
            o_done_q  <= done_q;
            o_cmd_q   <= l_cmd_q;
            o_seq_q   <= l_seq_q;
            o_len_q   <= l_len_q;
            o_upd_q   <= upd_q;
            o_tot_q   <= count_q;
            o_val_q   <= '0;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o       = out_vld_q;
  assign result_kind_o     = kind_q;
  assign frames_done_o     = o_done_q;
  assign last_command_o    = o_cmd_q;
  assign last_sequence_o   = o_seq_q;
  assign last_length_o     = o_len_q;
  assign capture_updated_o = o_upd_q;
  assign sample_total_o    = o_tot_q;
  assign sample_value_o    = o_val_q;

endmodule

FILE: test/tb_top.sv
// testbench for crc_frame_receiver_capture: framed link bytes and sample reads
// depends on cfrc_pkg and the crc_frame_receiver_capture rtl
`timescale 1ns / 100ps

module tb_top
  import cfrc_pkg::*;
;

  localparam logic OpByte     = 1'b0;
  localparam logic OpRead     = 1'b1;
  localparam logic KindFrame  = 1'b0;
  localparam logic KindSample = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [9:0]  done;
    logic [7:0]  cmd;
    logic [15:0] seq;
    logic [12:0] len;
    logic        updated;
    logic [11:0] total;
    logic [15:0] value;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        operation_i;
  logic [7:0]  link_byte_i;
  logic [10:0] sample_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  result_t     got;

  bit          quiet;
  int unsigned hold_left;
  int unsigned bytes_sent;
  bit [7:0]    pay_q[$];

  function automatic bit [15:0] modbus_step(bit [15:0] crc, bit [7:0] dat);
    bit [15:0] c;
    c = crc ^ {8'h00, dat};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  class capture_scoreboard;
    bit [7:0]    link_buf[FrameBytes];
    int unsigned fill;
    bit [15:0]   samples[MaxSamples];
    int unsigned count;
    result_t     expected_q[$];
    int unsigned errors;

    function new();
      fill = 0;
      count = 0;
      errors = 0;
    endfunction

    function void report(string what, logic [31:0] seen, logic [31:0] want);
      $display("tb: mismatch %s got %0h want %0h at %0t", what, seen, want, $realtime);
      errors++;
    endfunction

    // parse the buffer after each link byte, as the block does
    function void note_request(logic op, logic [7:0] lb, logic [10:0] idx);
      result_t     r;
      int unsigned head, avail, p, len, flen, ns, q;
      bit [15:0]   crc, rx;
      r = '0;
      if (op == OpRead) begin
        r.kind = KindSample;
        r.total = 12'(count);
        if (idx < count) r.value = samples[idx];
        expected_q.push_back(r);
        return;
      end
      if (fill < FrameBytes) begin
        link_buf[fill] = lb;
        fill++;
      end
      head = 0;
      avail = fill;
      while (avail >= 8) begin
        p = head;
        if (!(link_buf[p] == SyncFirst && link_buf[p+1] == SyncSecond)) begin
          head++;
          avail--;
          continue;
        end
        len = {link_buf[p+7], link_buf[p+6]};
        flen = len + 10;
        if (link_buf[p+2] != Version || flen > FrameBytes) begin
          head += 2;
          avail -= 2;
          continue;
        end
        if (avail < flen) break;
        rx = {link_buf[p+9+len], link_buf[p+8+len]};
        crc = CrcInit;
        for (int i = 0; i < 6 + len; i++) crc = modbus_step(crc, link_buf[p+2+i]);
        if (crc != rx) begin
          head += 2;
          avail -= 2;
          continue;
        end
        r.done++;
        r.cmd = link_buf[p+5];
        r.seq = {link_buf[p+4], link_buf[p+3]};
        r.len = 13'(len);
        if (r.cmd == CmdSamples && len >= 9) begin
          ns = {link_buf[p+14], link_buf[p+13]};
          if (ns > 0 && ns <= MaxSamples && 17 + ns * 2 <= 8 + len) begin
            for (int i = 0; i < ns; i++) begin
              q = p + 17 + i * 2;
              samples[i] = {link_buf[q+1], link_buf[q]};
            end
            count = ns;
            r.updated = 1'b1;
          end
        end
        head += flen;
        avail -= flen;
      end
      for (int i = 0; i < avail; i++) link_buf[i] = link_buf[head+i];
      fill = avail;
      if (r.done == 0) return;
      r.kind = KindFrame;
      r.total = 12'(count);
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t seen);
      result_t w;
      if (expected_q.size() == 0) begin
        report("unexpected result kind", seen.kind, 0);
        return;
      end
      w = expected_q.pop_front();
      if (seen.kind != w.kind) report("result_kind", seen.kind, w.kind);
      if (seen.done != w.done) report("frames_done", seen.done, w.done);
      if (seen.cmd != w.cmd) report("last_command", seen.cmd, w.cmd);
      if (seen.seq != w.seq) report("last_sequence", seen.seq, w.seq);
      if (seen.len != w.len) report("last_length", seen.len, w.len);
      if (seen.updated != w.updated) report("capture_updated", seen.updated, w.updated);
      if (seen.total != w.total) report("sample_total", seen.total, w.total);
      if (seen.value != w.value) report("sample_value", seen.value, w.value);
    endfunction
  endclass

  capture_scoreboard sb;

  crc_frame_receiver_capture u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .link_byte_i      (link_byte_i),
    .sample_index_i   (sample_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (got.kind),
    .frames_done_o    (got.done),
    .last_command_o   (got.cmd),
    .last_sequence_o  (got.seq),
    .last_length_o    (got.len),
    .capture_updated_o(got.updated),
    .sample_total_o   (got.total),
    .sample_value_o   (got.value)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit idle_now();
    return !quiet && $urandom_range(99) < 38;
  endfunction

  task automatic send_item(logic op, logic [7:0] lb, logic [10:0] idx);
    @(negedge clk_i);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    link_byte_i <= lb;
    sample_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, lb, idx);
    if (op == OpByte) bytes_sent++;
  endtask

  task automatic send_byte(logic [7:0] lb);
    send_item(OpByte, lb, 11'($urandom));
  endtask

  task automatic read_sample(logic [10:0] idx);
    send_item(OpRead, 8'($urandom), idx);
  endtask

  // sync, header, payload from pay_q, crc
  task automatic send_frame(bit [7:0] ver, bit [15:0] seq, bit [7:0] cmd, bit bad_crc);
    bit [7:0]  body[$];
    bit [15:0] len, crc;
    len = 16'(pay_q.size());
    body = {ver, seq[7:0], seq[15:8], cmd, len[7:0], len[15:8]};
    foreach (pay_q[i]) body.push_back(pay_q[i]);
    crc = CrcInit;
    foreach (body[i]) crc = modbus_step(crc, body[i]);
    if (bad_crc) crc ^= 16'(1 << $urandom_range(15));
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    foreach (body[i]) send_byte(body[i]);
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  task automatic header_only(bit [7:0] ver, bit [15:0] len);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(ver);
    repeat (3) send_byte(8'($urandom));
    send_byte(len[7:0]);
    send_byte(len[15:8]);
  endtask

  task automatic random_payload(int unsigned n);
    pay_q = {};
    repeat (n) pay_q.push_back(8'($urandom));
  endtask

  task automatic sample_payload(bit [15:0] ns_field, int unsigned n);
    random_payload(5);
    pay_q.push_back(ns_field[7:0]);
    pay_q.push_back(ns_field[15:8]);
    repeat (2 + 2 * n) pay_q.push_back(8'($urandom));
  endtask

  task automatic random_read();
    int unsigned top;
    if (sb.count > 0 && $urandom_range(3) != 0) begin
      top = (sb.count + 2 > 2047) ? 2047 : sb.count + 2;
      read_sample(11'($urandom_range(top)));
    end else begin
      read_sample(11'($urandom));
    end
  endtask

  initial begin
    int unsigned n, pick;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OpByte;
    link_byte_i = '0;
    sample_index_i = '0;
    quiet = 1'b0;
    bytes_sent = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty store, noise, field extremes, every frame rejection kind, bad sample counts
    read_sample(11'd0);
    read_sample(11'd2047);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SyncFirst);
    random_payload(0);
    send_frame(Version, 16'h0000, 8'h00, 1'b0);
    random_payload(3);
    send_frame(Version, 16'hFFFF, 8'hFF, 1'b0);
    random_payload(4);
    send_frame(8'h02, 16'h1234, 8'h11, 1'b0);
    send_frame(Version, 16'h1235, 8'h11, 1'b1);
    header_only(Version, 16'hFFFF);
    sample_payload(16'd1, 1);
    send_frame(Version, 16'h0100, CmdSamples, 1'b0);
    read_sample(11'd0);
    read_sample(11'd1);
    sample_payload(16'd0, 2);
    send_frame(Version, 16'h0101, CmdSamples, 1'b0);
    sample_payload(16'd9, 3);
    send_frame(Version, 16'h0102, CmdSamples, 1'b0);
    random_payload(5);
    send_frame(Version, 16'h0103, CmdSamples, 1'b0);
    sample_payload(16'd3, 3);
    send_frame(Version, 16'h0104, CmdSamples, 1'b0);
    read_sample(11'd2);
    read_sample(11'd3);

    // random: mostly well-formed frames, some noise, broken ones and sample reads
    n = 0;
    while (bytes_sent < 1900) begin
      quiet = (n >= 20 && n < 45);
      pick = $urandom_range(99);
      if (n == 60) begin
        sample_payload(16'd300, 300);
        send_frame(Version, 16'($urandom), CmdSamples, 1'b0);
        read_sample(11'd299);
      end else if (pick < 8) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(2))
            0: send_byte(SyncFirst);
            1: send_byte(SyncSecond);
            default: send_byte(8'($urandom));
          endcase
        end
      end else if (pick < 20) begin
        repeat ($urandom_range(1, 3)) random_read();
      end else if (pick < 30) begin
        random_payload($urandom_range(12));
        case ($urandom_range(2))
          0: send_frame(8'($urandom_range(2, 255)), 16'($urandom), 8'($urandom), 1'b0);
          1: send_frame(Version, 16'($urandom), 8'($urandom), 1'b1);
          default: header_only(Version, 16'($urandom_range(20, 70)));
        endcase
      end else if (pick < 50) begin
        case ($urandom_range(9))
          0: sample_payload(16'd0, $urandom_range(3));
          1: sample_payload(16'($urandom_range(5, 60)), $urandom_range(4));
          2: random_payload($urandom_range(8));
          default: begin
            pick = $urandom_range(1, 24);
            sample_payload(16'(pick), pick + $urandom_range(1));
          end
        endcase
        send_frame(Version, 16'($urandom), CmdSamples, 1'b0);
      end else begin
        random_payload($urandom_range(30));
        send_frame(Version, 16'($urandom), 8'($urandom), 1'b0);
      end
      n++;
    end
    random_payload(2);
    send_frame(Version, 16'h7777, 8'h21, 1'b0);
    random_read();
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin
    int unsigned cycles;
    cycles = 0;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      cycles++;
      if (cycles == 4000) hold_left = 3000;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= quiet || $urandom_range(99) >= 38;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(got);
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cfrc_pkg.sv
hw/rtl/crc_frame_receiver_capture.sv
test/tb_top.sv
